/* sv/irkf_pkg.sv */
// shared types, constants and register codes for the ir ranger kalman filter
`default_nettype none
package irkf_pkg;

  // defaults for top level parameters
  localparam int NumChannelsDef = 6;
  localparam int DistMaxDef     = 65;

  // field widths
  localparam int ChanW   = 3;
  localparam int SampleW = 10;
  localparam int RawW    = 7;
  localparam int DistW   = 8;   // internal distance, holds any DIST_MAX up to 255
  localparam int EstW    = 23;
  localparam int CovW    = 32;
  localparam int ChanCmpW = 5;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] REG_PROC_VAR = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SENS_VAR = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_INIT_COV = 2'd2;

  localparam logic [CovW-1:0] ProcVarRst = 32'd66;
  localparam logic [CovW-1:0] SensVarRst = 32'd65536;
  localparam logic [CovW-1:0] InitCovRst = 32'd65536;

  // distance conversion: round(2662.4/s) = floor((26624 + 5s) / 10s)
  localparam int DistNumW = 15;
  localparam logic [DistNumW-1:0] DistNumOfs = 15'd26624;
  localparam int DistQuotBits = 12;

  // shared divider
  localparam int DivRemW  = 34;
  localparam int DivLowW  = 17;
  localparam int DivDenW  = 33;
  localparam int DivStepW = 5;
  localparam int QuotW    = 17;
  localparam int GainNumW = 49;
  localparam logic [DivStepW-1:0] GainSteps = 5'd17;
  localparam logic [DivStepW-1:0] DistSteps = 5'd12;

  // shared multiply-accumulate
  localparam int MacAW = 17;
  localparam int MacBW = 32;
  localparam int AccW  = 49;
  localparam logic [MacAW-1:0] OneQ16  = 17'd65536;
  localparam logic [AccW-1:0]  HalfQ16 = 49'd32768;
  localparam logic [EstW-1:0]  EstMax  = 23'h7FFFFF;

  typedef struct packed {
    logic                load;
    logic [DivRemW-1:0]  rem;
    logic [DivLowW-1:0]  low;
    logic [DivStepW-1:0] steps;
    logic [DivDenW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic             en;
    logic             clear;
    logic [MacAW-1:0] a;
    logic [MacBW-1:0] b;
  } mac_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_DDIV,
    ST_PRED,
    ST_DEN,
    ST_GLOAD,
    ST_GDIV,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_FIN
  } state_e;

endpackage
`default_nettype wire

/* sv/irkf_div.sv */
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module irkf_div
  import irkf_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivRemW-1:0]  rem_q, rem_d;
  logic [DivLowW-1:0]  low_q, low_d;
  logic [DivStepW-1:0] cnt_q, cnt_d;
  logic [QuotW-1:0]    quot_q, quot_d;
  logic [DivDenW-1:0]  den_q, den_d;
  logic [DivRemW-1:0]  rem_sh;
  logic [DivRemW-1:0]  rem_sub;
  logic                fits;

  always_comb begin
    rem_sh  = {rem_q[DivRemW-2:0], low_q[DivLowW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = (rem_sh >= {1'b0, den_q});
    rem_d   = rem_q;
    low_d   = low_q;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    den_d   = den_q;
    if (req_i.load) begin
      rem_d  = req_i.rem;
      low_d  = req_i.low;
      cnt_d  = req_i.steps;
      quot_d = '0;
      den_d  = req_i.den;
    end else if (cnt_q != '0) begin
      rem_d  = fits ? rem_sub : rem_sh;
      low_d  = {low_q[DivLowW-2:0], 1'b0};
      quot_d = {quot_q[QuotW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = (cnt_q == '0) && !req_i.load;
  assign rsp_o.quot = quot_q;

endmodule
`default_nettype wire

/* sv/irkf_mac.sv */
// shared multiply-accumulate with q16 rounding offset on clear
`default_nettype none
module irkf_mac
  import irkf_pkg::*;
(
  input  wire            clk_i,
  input  mac_op_t        op_i,
  output logic [AccW-1:0] acc_o
);

  logic [AccW-1:0] acc_q, acc_d;
  logic [AccW-1:0] prod;

  always_comb begin
    prod  = AccW'(op_i.a) * AccW'(op_i.b);
    acc_d = acc_q;
    if (op_i.en) begin
      acc_d = (op_i.clear ? HalfQ16 : acc_q) + prod;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

/* sv/ir_ranger_kalman_filter.sv */
// six-channel ir ranger distance conversion with per-channel scalar kalman filter
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_ready_o    channel_i, sample_i
//  out      output     out_valid_o / out_ready_i  out_channel_o, raw_distance_o,
//                                                 filtered_distance_o
//  cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// for each item the single shared divider computes the distance (skipped on a zero
// sample) and then the gain (skipped when the gain denominator is zero), and the
// shared multiplier makes three passes.
// in_ready_o is high only between items; an item with an unused channel number is
// dropped in the idle state. the finished result sits in an output register, and the
// last step waits there while a previous result is still not transferred.
// reset restores the register defaults, zero estimates and initial covariances.
`default_nettype none
module ir_ranger_kalman_filter
  import irkf_pkg::*;
#(
  parameter int NUM_CHANNELS = NumChannelsDef,
  parameter int DIST_MAX     = DistMaxDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [ChanW-1:0]    channel_i,
  input  wire  [SampleW-1:0]  sample_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [ChanW-1:0]    out_channel_o,
  output logic [RawW-1:0]     raw_distance_o,
  output logic [EstW-1:0]     filtered_distance_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [CfgIdxW-1:0]  cfg_index_i,
  input  wire  [CfgDataW-1:0] cfg_data_i
);

  localparam int ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  state_e state_q, state_d;

  logic [CovW-1:0] proc_var_q, sens_var_q;
  logic [EstW-1:0] est_q [NUM_CHANNELS];
  logic [CovW-1:0] cov_q [NUM_CHANNELS];

  logic [ChanW-1:0]   ch_q;
  logic [SampleW-1:0] sample_q;
  logic [DistW-1:0]   raw_q;
  logic [CovW-1:0]    pc_q;
  logic [DivDenW-1:0] den_q;
  logic [QuotW-1:0]   g_q;
  logic               out_valid_q;
  logic [ChanW-1:0]   out_ch_q;
  logic [RawW-1:0]    out_raw_q;
  logic [EstW-1:0]    out_est_q;

  // control from the sequencer
  logic accept, raw_we, pc_we, den_we, g_we, cov_we, fin_we;
  div_req_t div_req;
  div_rsp_t div_rsp;
  mac_op_t  mac_op;
  logic [AccW-1:0] acc;

  // datapath terms
  logic [ChIdxW+ChanW-1:0] ch_wide;
  logic [ChIdxW-1:0]       ch_idx;
  logic                    ch_ok;
  logic [DistNumW-1:0]     dist_num;
  logic [DivDenW-1:0]      dist_den;
  logic [GainNumW-1:0]     gain_num;
  logic [CovW:0]           pc_sum;
  logic [EstW+2:0]         nx_full;
  logic [EstW-1:0]         nx;
  logic                    sample_zero;
  logic                    den_zero;
  logic                    out_free;
  logic [MacAW-1:0]        one_minus_g;

  assign ch_wide  = {{ChIdxW{1'b0}}, ch_q};
  assign ch_idx   = ch_wide[ChIdxW-1:0];
  assign ch_ok    = (ChanCmpW'(channel_i) < ChanCmpW'(NUM_CHANNELS));
  assign dist_num = DistNumOfs + DistNumW'({sample_q, 2'b00}) + DistNumW'(sample_q);
  assign dist_den = DivDenW'({sample_q, 3'b000}) + DivDenW'({sample_q, 1'b0});
  assign gain_num = GainNumW'({pc_q, 16'h0000}) + GainNumW'(den_q[DivDenW-1:1]);
  assign pc_sum   = {1'b0, cov_q[ch_idx]} + {1'b0, proc_var_q};
  assign nx_full  = acc[EstW+18:16];
  assign nx       = (nx_full > (EstW+3)'(EstMax)) ? EstMax : nx_full[EstW-1:0];
  assign sample_zero = (sample_q == '0);
  assign den_zero    = (den_q == '0);
  assign out_free    = !out_valid_q || out_ready_i;
  assign one_minus_g = OneQ16 - g_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i && ch_ok) state_d = ST_DIST;
      ST_DIST:  state_d = sample_zero ? ST_PRED : ST_DDIV;
      ST_DDIV:  if (div_rsp.done) state_d = ST_PRED;
      ST_PRED:  state_d = ST_DEN;
      ST_DEN:   state_d = ST_GLOAD;
      ST_GLOAD: state_d = den_zero ? ST_MUL1 : ST_GDIV;
      ST_GDIV:  if (div_rsp.done) state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_MUL3;
      ST_MUL3:  state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    accept     = 1'b0;
    raw_we     = 1'b0;
    pc_we      = 1'b0;
    den_we     = 1'b0;
    g_we       = 1'b0;
    cov_we     = 1'b0;
    fin_we     = 1'b0;
    div_req    = '0;
    mac_op     = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
      end
      ST_DIST: begin
        if (sample_zero) begin
          raw_we = 1'b1;
        end else begin
          div_req.load  = 1'b1;
          div_req.rem   = DivRemW'(dist_num[DistNumW-1:DistQuotBits]);
          div_req.low   = {dist_num[DistQuotBits-1:0], {(DivLowW-DistQuotBits){1'b0}}};
          div_req.steps = DistSteps;
          div_req.den   = dist_den;
        end
      end
      ST_DDIV:  raw_we = div_rsp.done;
      ST_PRED:  pc_we  = 1'b1;
      ST_DEN:   den_we = 1'b1;
      ST_GLOAD: begin
        if (den_zero) begin
          g_we = 1'b1;
        end else begin
          div_req.load  = 1'b1;
          div_req.rem   = DivRemW'(gain_num[GainNumW-1:DivLowW]);
          div_req.low   = gain_num[DivLowW-1:0];
          div_req.steps = GainSteps;
          div_req.den   = den_q;
        end
      end
      ST_GDIV:  g_we = div_rsp.done;
      ST_MUL1: begin
        mac_op.en    = 1'b1;
        mac_op.clear = 1'b1;
        mac_op.a     = one_minus_g;
        mac_op.b     = pc_q;
      end
      ST_MUL2: begin
        cov_we       = 1'b1;
        mac_op.en    = 1'b1;
        mac_op.clear = 1'b1;
        mac_op.a     = one_minus_g;
        mac_op.b     = MacBW'(est_q[ch_idx]);
      end
      ST_MUL3: begin
        mac_op.en = 1'b1;
        mac_op.a  = g_q;
        mac_op.b  = MacBW'({raw_q, 16'h0000});
      end
      ST_FIN:   fin_we = out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  irkf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  irkf_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .acc_o (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers and per-channel filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_var_q <= ProcVarRst;
      sens_var_q <= SensVarRst;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        est_q[i] <= '0;
        cov_q[i] <= InitCovRst;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PROC_VAR: proc_var_q <= cfg_data_i;
          REG_SENS_VAR: sens_var_q <= cfg_data_i;
          REG_INIT_COV: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              cov_q[i] <= cfg_data_i;
            end
          end
          default: ;
        endcase
      end
      if (cov_we) begin
        cov_q[ch_idx] <= acc[CovW+15:16];
      end
      if (fin_we) begin
        est_q[ch_idx] <= nx;
      end
    end
  end

  // working registers of the current item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q     <= channel_i;
      sample_q <= sample_i;
    end
    if (raw_we) begin
      if (sample_zero || (div_rsp.quot[DistQuotBits-1:0] > DistQuotBits'(DIST_MAX))) begin
        raw_q <= DistW'(DIST_MAX);
      end else begin
        raw_q <= div_rsp.quot[DistW-1:0];
      end
    end
    if (pc_we) begin
      pc_q <= pc_sum[CovW] ? {CovW{1'b1}} : pc_sum[CovW-1:0];
    end
    if (den_we) begin
      den_q <= {1'b0, pc_q} + {1'b0, sens_var_q};
    end
    if (g_we) begin
      g_q <= den_zero ? '0 : div_rsp.quot;
    end
    if (fin_we) begin
      out_ch_q  <= ch_q;
      out_raw_q <= raw_q[RawW-1:0];
      out_est_q <= nx;
    end
  end

  // output register, one result waiting for transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_we) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign cfg_ready_o         = 1'b1;
  assign out_valid_o         = out_valid_q;
  assign out_channel_o       = out_ch_q;
  assign raw_distance_o      = out_raw_q;
  assign filtered_distance_o = out_est_q;

endmodule
`default_nettype wire

/* bench/ir_ranger_kalman_filter_tb.sv */
// testbench for the ir ranger kalman filter: directed and random samples checked by a scoreboard
`timescale 1ns / 1ps
module ir_ranger_kalman_filter_tb
  import irkf_pkg::*;
;

  localparam int ClkPeriod    = 10;
  localparam int NumCh        = NumChannelsDef;
  localparam int DistMax      = DistMaxDef;
  localparam int SettleCycles = 48;
  localparam int MaxReports   = 10;
  localparam int TimeoutNs    = 5_000_000;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct {
    logic [ChanW-1:0] chan;
    logic [RawW-1:0]  raw;
    logic [EstW-1:0]  est;
  } reading_t;

  class ranger_scoreboard;
    reading_t         expected_readings[$];
    logic [CovW-1:0]  proc_var;
    logic [CovW-1:0]  sens_var;
    logic [CovW-1:0]  init_cov;
    logic [CovW-1:0]  cov_q[NumCh];
    logic [EstW-1:0]  est_q[NumCh];
    int               mismatch_count;

    function new();
      proc_var = ProcVarRst;
      sens_var = SensVarRst;
      init_cov = InitCovRst;
      mismatch_count = 0;
      foreach (cov_q[i]) begin
        cov_q[i] = InitCovRst;
        est_q[i] = '0;
      end
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_PROC_VAR: proc_var = data;
        REG_SENS_VAR: sens_var = data;
        REG_INIT_COV: begin
          init_cov = data;
          foreach (cov_q[i]) cov_q[i] = data;
        end
        default: ;
      endcase
    endfunction

    // one filter step for an accepted sample
    function void note_sample(logic [ChanW-1:0] ch, logic [SampleW-1:0] s);
      longint unsigned sv, dist_cm, pc, den, g, np, x, z, nx;
      reading_t        r;
      if (ch >= NumCh) return;
      sv = s;
      if (sv == 0) begin
        dist_cm = DistMax;
      end else begin
        dist_cm = (DistNumOfs + 5 * sv) / (10 * sv);
        if (dist_cm > DistMax) dist_cm = DistMax;
      end
      pc = cov_q[ch];
      pc += proc_var;
      if (pc > 64'hFFFF_FFFF) pc = 64'hFFFF_FFFF;
      den = pc + sens_var;
      if (den == 0) g = 0;
      else g = ((pc << 16) + (den >> 1)) / den;
      if (g > OneQ16) g = OneQ16;
      np = ((OneQ16 - g) * pc + HalfQ16) >> 16;
      cov_q[ch] = np[CovW-1:0];
      x = est_q[ch];
      z = dist_cm << 16;
      nx = ((OneQ16 - g) * x + g * z + HalfQ16) >> 16;
      if (nx > EstMax) nx = EstMax;
      est_q[ch] = nx[EstW-1:0];
      r.chan = ch;
      r.raw  = dist_cm[RawW-1:0];
      r.est  = nx[EstW-1:0];
      expected_readings.push_back(r);
    endfunction

    function void flag(string what);
      mismatch_count++;
      if (mismatch_count <= MaxReports) $display("mismatch: %s", what);
    endfunction

    function void check_reading(logic [ChanW-1:0] ch, logic [RawW-1:0] raw,
                                logic [EstW-1:0] est);
      reading_t want;
      if (expected_readings.size() == 0) begin
        flag($sformatf("unexpected result ch=%0d raw=%0d est=%h", ch, raw, est));
        return;
      end
      want = expected_readings.pop_front();
      if (ch !== want.chan)
        flag($sformatf("out_channel expected %0d got %0d", want.chan, ch));
      if (raw !== want.raw)
        flag($sformatf("raw_distance ch%0d expected %0d got %0d", want.chan, want.raw, raw));
      if (est !== want.est)
        flag($sformatf("filtered_distance ch%0d expected %h got %h",
                       want.chan, want.est, est));
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [ChanW-1:0]    channel_i = '0;
  logic [SampleW-1:0]  sample_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ChanW-1:0]    out_channel_o;
  logic [RawW-1:0]     raw_distance_o;
  logic [EstW-1:0]     filtered_distance_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  bit                  idle_on = 1'b1;
  ranger_scoreboard    sb = new();

  ir_ranger_kalman_filter uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .channel_i          (channel_i),
    .sample_i           (sample_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_channel_o      (out_channel_o),
    .raw_distance_o     (raw_distance_o),
    .filtered_distance_o(filtered_distance_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // handshakes are sampled at the falling edge, the transfer happens at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i)
      sb.check_reading(out_channel_o, raw_distance_o, filtered_distance_o);
  end

  initial begin : sink_stalls
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("status: fail");
    $finish;
  end

  // called at a rising edge; valid stays high so the next sample can follow directly
  task automatic send_sample(logic [ChanW-1:0] ch, logic [SampleW-1:0] s);
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= s;
    do @(negedge clk_i); while (in_ready_o !== 1'b1);
    @(posedge clk_i);
    sb.note_sample(ch, s);
  endtask

  task automatic pause_input(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // dropped samples may still be in flight
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (cfg_ready_o !== 1'b1);
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic load_filter_regs(logic [CfgDataW-1:0] q, logic [CfgDataW-1:0] r,
                                  logic [CfgDataW-1:0] p, bit poke_unused);
    drain_results();
    write_reg(REG_PROC_VAR, q);
    write_reg(REG_SENS_VAR, r);
    write_reg(REG_INIT_COV, p);
    if (poke_unused) write_reg(RegUnused, $urandom());
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_samples(int count, bit mid_drain);
    int               sent;
    logic [ChanW-1:0] ch;
    logic [SampleW-1:0] s;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 15) == 0) ch = $urandom_range(NumCh, 7);
      else ch = $urandom_range(0, NumCh - 1);
      case ($urandom_range(0, 9))
        0:       s = '0;
        1, 2:    s = $urandom_range(1, 60);
        default: s = $urandom_range(0, 1023);
      endcase
      send_sample(ch, s);
      if (ch < NumCh) sent++;
      if (mid_drain && sent == count / 2) begin
        drain_results();
        mid_drain = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        pause_input($urandom_range(1, 16));
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: field extremes, saturation edge, unused channels
    send_sample(3'd0, 10'd0);
    send_sample(3'd1, 10'd1);
    send_sample(3'd2, 10'h3FF);
    send_sample(3'd3, 10'h200);
    send_sample(3'd4, 10'h1FF);
    pause_input(3);
    send_sample(3'd5, 10'd40);
    send_sample(3'd0, 10'd41);
    send_sample(3'd1, 10'd42);
    send_sample(3'd6, 10'd100);
    send_sample(3'd7, 10'h3FF);
    send_sample(3'd5, 10'h155);
    send_sample(3'd4, 10'h2AA);
    pause_input(9);
    send_sample(3'd0, 10'd100);
    send_sample(3'd0, 10'd100);
    send_sample(3'd0, 10'd100);
    send_sample(3'd0, 10'd0);
    send_sample(3'd3, 10'd1023);
    send_sample(3'd2, 10'd27);
    run_samples(50, 1'b0);

    // both variances and covariance zero: gain stays zero
    load_filter_regs('0, '0, '0, 1'b1);
    send_sample(3'd0, 10'd5);
    send_sample(3'd1, 10'd0);
    run_samples(38, 1'b0);

    // saturating predicted covariance, gain of one
    load_filter_regs('1, '0, '1, 1'b0);
    run_samples(40, 1'b0);

    load_filter_regs('1, '1, '0, 1'b1);
    run_samples(40, 1'b0);

    load_filter_regs('0, '1, '1, 1'b0);
    run_samples(40, 1'b0);

    load_filter_regs($urandom(), $urandom(), $urandom(), 1'b1);
    run_samples(70, 1'b1);

    load_filter_regs($urandom_range(0, 1 << 16), $urandom_range(1 << 12, 1 << 22),
                     $urandom_range(0, 1 << 20), 1'b0);
    run_samples(70, 1'b0);

    // back to defaults, full throughput to the end
    load_filter_regs(ProcVarRst, SensVarRst, InitCovRst, 1'b0);
    idle_on = 1'b0;
    run_samples(80, 1'b0);

    drain_results();
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      if (sb.pending() != 0) $display("missing %0d results", sb.pending());
      $display("status: fail");
    end
    $finish;
  end

endmodule
